>>> rtl/acmc_pkg.sv
// ----------------------------------------------------------------------------
// acmc_pkg
// Shared types and constants of the multi-pattern match counter: commands,
// status codes, controller states, datapath operations, control structs.
// ----------------------------------------------------------------------------
package acmc_pkg;

	localparam int NODES_DEF    = 4096;
	localparam int ALPHABET_DEF = 32;
	localparam int CMD_W        = 3;
	localparam int SYM_W        = 5;
	localparam int MATCH_W      = 16;
	localparam int TOTAL_W      = 48;
	localparam int STATUS_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 3'd0,
		CMD_PATTERN = 3'd1,
		CMD_END     = 3'd2,
		CMD_BUILD   = 3'd3,
		CMD_TEXT    = 3'd4,
		CMD_RESTART = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOLINKS = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_RST_CLR,
		S_IDLE,
		S_DISPATCH,
		S_CLR_ROW,
		S_INS_CHK,
		S_ALLOC_ROW,
		S_INS_LINK,
		S_END_WR,
		S_BLD_POP,
		S_BLD_PAR,
		S_BLD_RDCH,
		S_BLD_CHK,
		S_BLD_FLOAD,
		S_BLD_FRD,
		S_BLD_FCHK,
		S_BLD_SETF,
		S_BLD_SETD,
		S_BLD_NEXTS,
		S_TX_RD,
		S_TX_CHK,
		S_TX_FLOAD,
		S_TX_SET,
		S_TX_WALK,
		S_TX_ACC,
		S_TX_SUM,
		S_FINISH
	} state_t;

	typedef enum logic [5:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR_INIT,
		OP_CLR_ROW,
		OP_INS_RD,
		OP_INS_ADV,
		OP_SET_FULL,
		OP_ALLOC,
		OP_INS_LINK,
		OP_END_RD,
		OP_END_WR,
		OP_BLD_INIT,
		OP_BLD_POP,
		OP_BLD_PAR,
		OP_BLD_RDCH,
		OP_BLD_CHK,
		OP_F_LOAD,
		OP_F_RDCH,
		OP_F_CHK,
		OP_SETF,
		OP_SETD,
		OP_NEXTS,
		OP_BLD_DONE,
		OP_TX_NOLINK,
		OP_TX_ROOT,
		OP_TX_START,
		OP_TX_RD,
		OP_TX_CHK,
		OP_TX_FLOAD,
		OP_TX_SET,
		OP_TX_WALK,
		OP_TX_ACC,
		OP_TX_SUM,
		OP_RESTART,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             sym_ok;
		logic             child_nz;
		logic             par_root;
		logic             f_root;
		logic             cur_root;
		logic             store_full;
		logic             links_built;
		logic             queue_empty;
		logic             row_last;
		logic             s_last;
		logic             out_busy;
	} dp_status_t;

endpackage

>>> rtl/acmc_ctrl.sv
// ----------------------------------------------------------------------------
// acmc_ctrl
// Sequencer of the match counter: decodes each request and steps the
// datapath through clearing, insertion, pattern end, link build and text walks.
// ----------------------------------------------------------------------------
module acmc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output acmc_pkg::dp_cmd_t    dp_cmd,
	input  acmc_pkg::dp_status_t dp_st
);

	acmc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acmc_pkg::S_RST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		dp_cmd.op = acmc_pkg::OP_NONE;
		case (state_q)
			acmc_pkg::S_RST_CLR: begin
				dp_cmd.op = acmc_pkg::OP_CLR_ROW;
				if (dp_st.row_last) state_d = acmc_pkg::S_IDLE;
			end
			acmc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_cmd.op = acmc_pkg::OP_LOAD;
					state_d   = acmc_pkg::S_DISPATCH;
				end
			end
			acmc_pkg::S_DISPATCH: begin
				state_d = acmc_pkg::S_FINISH;
				case (dp_st.cmd)
					acmc_pkg::CMD_CLEAR: begin
						dp_cmd.op = acmc_pkg::OP_CLR_INIT;
						state_d   = acmc_pkg::S_CLR_ROW;
					end
					acmc_pkg::CMD_PATTERN: begin
						if (dp_st.sym_ok) begin
							dp_cmd.op = acmc_pkg::OP_INS_RD;
							state_d   = acmc_pkg::S_INS_CHK;
						end
					end
					acmc_pkg::CMD_END: begin
						dp_cmd.op = acmc_pkg::OP_END_RD;
						state_d   = acmc_pkg::S_END_WR;
					end
					acmc_pkg::CMD_BUILD: begin
						dp_cmd.op = acmc_pkg::OP_BLD_INIT;
						state_d   = acmc_pkg::S_BLD_POP;
					end
					acmc_pkg::CMD_TEXT: begin
						if (!dp_st.links_built) begin
							dp_cmd.op = acmc_pkg::OP_TX_NOLINK;
						end else if (!dp_st.sym_ok) begin
							dp_cmd.op = acmc_pkg::OP_TX_ROOT;
							state_d   = acmc_pkg::S_TX_SET;
						end else begin
							dp_cmd.op = acmc_pkg::OP_TX_START;
							state_d   = acmc_pkg::S_TX_RD;
						end
					end
					acmc_pkg::CMD_RESTART: dp_cmd.op = acmc_pkg::OP_RESTART;
					default: dp_cmd.op = acmc_pkg::OP_NONE;
				endcase
			end
			acmc_pkg::S_CLR_ROW: begin
				dp_cmd.op = acmc_pkg::OP_CLR_ROW;
				if (dp_st.row_last) state_d = acmc_pkg::S_FINISH;
			end
			acmc_pkg::S_INS_CHK: begin
				if (dp_st.child_nz) begin
					dp_cmd.op = acmc_pkg::OP_INS_ADV;
					state_d   = acmc_pkg::S_FINISH;
				end else if (dp_st.store_full) begin
					dp_cmd.op = acmc_pkg::OP_SET_FULL;
					state_d   = acmc_pkg::S_FINISH;
				end else begin
					dp_cmd.op = acmc_pkg::OP_ALLOC;
					state_d   = acmc_pkg::S_ALLOC_ROW;
				end
			end
			acmc_pkg::S_ALLOC_ROW: begin
				dp_cmd.op = acmc_pkg::OP_CLR_ROW;
				if (dp_st.row_last) state_d = acmc_pkg::S_INS_LINK;
			end
			acmc_pkg::S_INS_LINK: begin
				dp_cmd.op = acmc_pkg::OP_INS_LINK;
				state_d   = acmc_pkg::S_FINISH;
			end
			acmc_pkg::S_END_WR: begin
				dp_cmd.op = acmc_pkg::OP_END_WR;
				state_d   = acmc_pkg::S_FINISH;
			end
			acmc_pkg::S_BLD_POP: begin
				if (dp_st.queue_empty) begin
					dp_cmd.op = acmc_pkg::OP_BLD_DONE;
					state_d   = acmc_pkg::S_FINISH;
				end else begin
					dp_cmd.op = acmc_pkg::OP_BLD_POP;
					state_d   = acmc_pkg::S_BLD_PAR;
				end
			end
			acmc_pkg::S_BLD_PAR: begin
				dp_cmd.op = acmc_pkg::OP_BLD_PAR;
				state_d   = acmc_pkg::S_BLD_RDCH;
			end
			acmc_pkg::S_BLD_RDCH: begin
				dp_cmd.op = acmc_pkg::OP_BLD_RDCH;
				state_d   = acmc_pkg::S_BLD_CHK;
			end
			acmc_pkg::S_BLD_CHK: begin
				dp_cmd.op = acmc_pkg::OP_BLD_CHK;
				if (!dp_st.child_nz) state_d = acmc_pkg::S_BLD_NEXTS;
				else if (dp_st.par_root) state_d = acmc_pkg::S_BLD_SETF;
				else state_d = acmc_pkg::S_BLD_FLOAD;
			end
			acmc_pkg::S_BLD_FLOAD: begin
				dp_cmd.op = acmc_pkg::OP_F_LOAD;
				state_d   = acmc_pkg::S_BLD_FRD;
			end
			acmc_pkg::S_BLD_FRD: begin
				dp_cmd.op = acmc_pkg::OP_F_RDCH;
				state_d   = acmc_pkg::S_BLD_FCHK;
			end
			acmc_pkg::S_BLD_FCHK: begin
				dp_cmd.op = acmc_pkg::OP_F_CHK;
				if (dp_st.child_nz || dp_st.f_root) state_d = acmc_pkg::S_BLD_SETF;
				else state_d = acmc_pkg::S_BLD_FLOAD;
			end
			acmc_pkg::S_BLD_SETF: begin
				dp_cmd.op = acmc_pkg::OP_SETF;
				state_d   = acmc_pkg::S_BLD_SETD;
			end
			acmc_pkg::S_BLD_SETD: begin
				dp_cmd.op = acmc_pkg::OP_SETD;
				state_d   = acmc_pkg::S_BLD_NEXTS;
			end
			acmc_pkg::S_BLD_NEXTS: begin
				dp_cmd.op = acmc_pkg::OP_NEXTS;
				state_d   = dp_st.s_last ? acmc_pkg::S_BLD_POP : acmc_pkg::S_BLD_RDCH;
			end
			acmc_pkg::S_TX_RD: begin
				dp_cmd.op = acmc_pkg::OP_TX_RD;
				state_d   = acmc_pkg::S_TX_CHK;
			end
			acmc_pkg::S_TX_CHK: begin
				dp_cmd.op = acmc_pkg::OP_TX_CHK;
				if (dp_st.child_nz || dp_st.cur_root) state_d = acmc_pkg::S_TX_SET;
				else state_d = acmc_pkg::S_TX_FLOAD;
			end
			acmc_pkg::S_TX_FLOAD: begin
				dp_cmd.op = acmc_pkg::OP_TX_FLOAD;
				state_d   = acmc_pkg::S_TX_RD;
			end
			acmc_pkg::S_TX_SET: begin
				dp_cmd.op = acmc_pkg::OP_TX_SET;
				state_d   = dp_st.cur_root ? acmc_pkg::S_TX_SUM : acmc_pkg::S_TX_ACC;
			end
			acmc_pkg::S_TX_WALK: begin
				dp_cmd.op = acmc_pkg::OP_TX_WALK;
				state_d   = dp_st.cur_root ? acmc_pkg::S_TX_SUM : acmc_pkg::S_TX_ACC;
			end
			acmc_pkg::S_TX_ACC: begin
				dp_cmd.op = acmc_pkg::OP_TX_ACC;
				state_d   = acmc_pkg::S_TX_WALK;
			end
			acmc_pkg::S_TX_SUM: begin
				dp_cmd.op = acmc_pkg::OP_TX_SUM;
				state_d   = acmc_pkg::S_FINISH;
			end
			acmc_pkg::S_FINISH: begin
				if (!dp_st.out_busy) begin
					dp_cmd.op = acmc_pkg::OP_FINISH;
					state_d   = acmc_pkg::S_IDLE;
				end
			end
			default: state_d = acmc_pkg::S_IDLE;
		endcase
	end

endmodule

>>> rtl/acmc_datapath.sv
// ----------------------------------------------------------------------------
// acmc_datapath
// Node store memories, breadth-first queue, walk registers, saturating
// counters and the output register of the match counter.
// ----------------------------------------------------------------------------
module acmc_datapath #(
	parameter int NODES    = acmc_pkg::NODES_DEF,
	parameter int ALPHABET = acmc_pkg::ALPHABET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [acmc_pkg::CMD_W-1:0]    command,
	input  logic [acmc_pkg::SYM_W-1:0]    symbol,
	input  acmc_pkg::dp_cmd_t             dp_cmd,
	output acmc_pkg::dp_status_t          dp_st,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [acmc_pkg::MATCH_W-1:0]  match_count,
	output logic [acmc_pkg::TOTAL_W-1:0]  total_matches,
	output logic [acmc_pkg::STATUS_W-1:0] status
);

	localparam int NW = $clog2(NODES);
	localparam int SW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int AW = NW + SW;
	localparam int MW = acmc_pkg::MATCH_W;
	localparam int TW = acmc_pkg::TOTAL_W;

	logic [NW-1:0] child_mem [(2**AW)-1:0];
	logic [NW-1:0] fail_mem  [NODES-1:0];
	logic [NW-1:0] dict_mem  [NODES-1:0];
	logic [MW-1:0] end_mem   [NODES-1:0];
	logic [NW-1:0] queue_mem [NODES-1:0];

	logic [NW-1:0] child_rd, fail_rd, dict_rd, queue_rd;
	logic [MW-1:0] end_rd;

	logic [acmc_pkg::CMD_W-1:0]  cmd_q;
	logic [acmc_pkg::SYM_W-1:0]  sym_q;
	logic [NW:0]                 nodes_used_q;
	logic [NW-1:0]               insert_q, text_q, cur_q, par_q, f_q, nxt_q, clr_node_q;
	logic [SW-1:0]               clr_cnt_q, s_q;
	logic [NW:0]                 head_q, tail_q;
	logic                        links_q;
	logic [TW-1:0]               total_q;
	logic [MW-1:0]               cnt_q, res_match_q;
	logic [acmc_pkg::STATUS_W-1:0] res_status_q;
	logic                        out_valid_q;
	logic [MW-1:0]               out_match_q;
	logic [TW-1:0]               out_total_q;
	logic [acmc_pkg::STATUS_W-1:0] out_status_q;

	logic [SW-1:0] sym_idx;
	logic [AW-1:0] child_raddr, child_waddr;
	logic          child_we;
	logic [NW-1:0] child_wdata;
	logic [NW-1:0] fail_raddr, end_raddr, dict_raddr;
	logic          fail_we, dict_we, end_we, queue_we;
	logic [NW-1:0] fail_waddr, dict_waddr, end_waddr;
	logic [NW-1:0] fail_wdata, dict_wdata;
	logic [MW-1:0] end_wdata;
	logic [MW:0]   cnt_sum;
	logic [TW:0]   total_sum;
	logic          child_nz;

	assign sym_idx   = SW'(sym_q);
	assign child_nz  = (child_rd != '0);
	assign cnt_sum   = {1'b0, cnt_q} + {1'b0, end_rd};
	assign total_sum = {1'b0, total_q} + {{(TW+1-MW){1'b0}}, cnt_q};

	// read and write address selection per operation
	always_comb begin
		child_raddr = {insert_q, sym_idx};
		fail_raddr  = cur_q;
		end_raddr   = cur_q;
		dict_raddr  = cur_q;
		child_we    = 1'b0;
		child_waddr = {clr_node_q, clr_cnt_q};
		child_wdata = '0;
		fail_we     = 1'b0;
		fail_waddr  = nxt_q;
		fail_wdata  = f_q;
		dict_we     = 1'b0;
		dict_waddr  = nxt_q;
		dict_wdata  = (end_rd != '0) ? f_q : dict_rd;
		end_we      = 1'b0;
		end_waddr   = clr_node_q;
		end_wdata   = '0;
		queue_we    = 1'b0;
		case (dp_cmd.op)
			acmc_pkg::OP_CLR_ROW: begin
				child_we = 1'b1;
				end_we   = 1'b1;
			end
			acmc_pkg::OP_INS_LINK: begin
				child_we    = 1'b1;
				child_waddr = {insert_q, sym_idx};
				child_wdata = clr_node_q;
			end
			acmc_pkg::OP_END_RD: end_raddr = insert_q;
			acmc_pkg::OP_END_WR: begin
				end_we    = 1'b1;
				end_waddr = insert_q;
				end_wdata = (end_rd == '1) ? end_rd : end_rd + MW'(1);
			end
			acmc_pkg::OP_BLD_INIT: begin
				fail_we    = 1'b1;
				fail_waddr = '0;
				fail_wdata = '0;
				dict_we    = 1'b1;
				dict_waddr = '0;
				dict_wdata = '0;
				queue_we   = 1'b1;
			end
			acmc_pkg::OP_BLD_RDCH: child_raddr = {par_q, s_q};
			acmc_pkg::OP_BLD_CHK:  fail_raddr  = par_q;
			acmc_pkg::OP_F_RDCH:   child_raddr = {f_q, s_q};
			acmc_pkg::OP_F_CHK:    fail_raddr  = f_q;
			acmc_pkg::OP_SETF: begin
				fail_we    = 1'b1;
				end_raddr  = f_q;
				dict_raddr = f_q;
			end
			acmc_pkg::OP_SETD: begin
				dict_we  = 1'b1;
				queue_we = 1'b1;
			end
			acmc_pkg::OP_TX_RD: child_raddr = {cur_q, sym_idx};
			default: child_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (child_we) child_mem[child_waddr] <= child_wdata;
		child_rd <= child_mem[child_raddr];
	end

	always_ff @(posedge clk) begin
		if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
		fail_rd <= fail_mem[fail_raddr];
	end

	always_ff @(posedge clk) begin
		if (dict_we) dict_mem[dict_waddr] <= dict_wdata;
		dict_rd <= dict_mem[dict_raddr];
	end

	always_ff @(posedge clk) begin
		if (end_we) end_mem[end_waddr] <= end_wdata;
		end_rd <= end_mem[end_raddr];
	end

	// root is pushed at init, children at the tail afterwards
	always_ff @(posedge clk) begin
		if (queue_we) queue_mem[tail_q[NW-1:0]] <= (dp_cmd.op == acmc_pkg::OP_SETD) ? nxt_q : '0;
		queue_rd <= queue_mem[head_q[NW-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_used_q <= (NW+1)'(1);
			insert_q     <= '0;
			text_q       <= '0;
			links_q      <= 1'b0;
			total_q      <= '0;
			clr_node_q   <= '0;
			clr_cnt_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (dp_cmd.op == acmc_pkg::OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (dp_cmd.op)
				acmc_pkg::OP_CLR_INIT: begin
					nodes_used_q <= (NW+1)'(1);
					insert_q     <= '0;
					text_q       <= '0;
					links_q      <= 1'b0;
					total_q      <= '0;
					clr_node_q   <= '0;
					clr_cnt_q    <= '0;
				end
				acmc_pkg::OP_CLR_ROW: begin
					clr_cnt_q <= (clr_cnt_q == SW'(ALPHABET-1)) ? '0 : clr_cnt_q + SW'(1);
				end
				acmc_pkg::OP_INS_ADV: begin
					insert_q <= child_rd;
					links_q  <= 1'b0;
				end
				acmc_pkg::OP_ALLOC: begin
					clr_node_q   <= nodes_used_q[NW-1:0];
					clr_cnt_q    <= '0;
					nodes_used_q <= nodes_used_q + (NW+1)'(1);
				end
				acmc_pkg::OP_INS_LINK: begin
					insert_q <= clr_node_q;
					links_q  <= 1'b0;
				end
				acmc_pkg::OP_END_WR: begin
					insert_q <= '0;
					links_q  <= 1'b0;
				end
				acmc_pkg::OP_BLD_INIT: begin
					head_q <= '0;
					tail_q <= (NW+1)'(1);
				end
				acmc_pkg::OP_BLD_POP: head_q <= head_q + (NW+1)'(1);
				acmc_pkg::OP_SETD:    tail_q <= tail_q + (NW+1)'(1);
				acmc_pkg::OP_BLD_DONE: begin
					links_q <= 1'b1;
					text_q  <= '0;
				end
				acmc_pkg::OP_TX_SET: text_q <= cur_q;
				acmc_pkg::OP_TX_SUM: begin
					total_q <= total_sum[TW] ? '1 : total_sum[TW-1:0];
				end
				acmc_pkg::OP_RESTART: begin
					text_q  <= '0;
					total_q <= '0;
				end
				default: links_q <= links_q;
			endcase
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		case (dp_cmd.op)
			acmc_pkg::OP_LOAD: begin
				cmd_q        <= command;
				sym_q        <= symbol;
				res_match_q  <= '0;
				res_status_q <= acmc_pkg::ST_OK;
			end
			acmc_pkg::OP_SET_FULL:  res_status_q <= acmc_pkg::ST_FULL;
			acmc_pkg::OP_TX_NOLINK: res_status_q <= acmc_pkg::ST_NOLINKS;
			acmc_pkg::OP_BLD_PAR: begin
				par_q <= queue_rd;
				s_q   <= '0;
			end
			acmc_pkg::OP_BLD_CHK: begin
				nxt_q <= child_rd;
				f_q   <= '0;
			end
			acmc_pkg::OP_F_LOAD: f_q <= fail_rd;
			acmc_pkg::OP_F_CHK:  if (child_nz) f_q <= child_rd;
			acmc_pkg::OP_NEXTS:  s_q <= s_q + SW'(1);
			acmc_pkg::OP_TX_ROOT:  cur_q <= '0;
			acmc_pkg::OP_TX_START: cur_q <= text_q;
			acmc_pkg::OP_TX_CHK:   if (child_nz) cur_q <= child_rd;
			acmc_pkg::OP_TX_FLOAD: cur_q <= fail_rd;
			acmc_pkg::OP_TX_SET:   cnt_q <= '0;
			acmc_pkg::OP_TX_ACC: begin
				cnt_q <= cnt_sum[MW] ? '1 : cnt_sum[MW-1:0];
				cur_q <= dict_rd;
			end
			acmc_pkg::OP_TX_SUM: res_match_q <= cnt_q;
			acmc_pkg::OP_FINISH: begin
				out_match_q  <= res_match_q;
				out_total_q  <= total_q;
				out_status_q <= res_status_q;
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	assign dp_st.cmd         = cmd_q;
	assign dp_st.sym_ok      = (32'(sym_q) < ALPHABET);
	assign dp_st.child_nz    = child_nz;
	assign dp_st.par_root    = (par_q == '0);
	assign dp_st.f_root      = (f_q == '0);
	assign dp_st.cur_root    = (cur_q == '0);
	assign dp_st.store_full  = (nodes_used_q == (NW+1)'(NODES));
	assign dp_st.links_built = links_q;
	assign dp_st.queue_empty = (head_q == tail_q);
	assign dp_st.row_last    = (clr_cnt_q == SW'(ALPHABET-1));
	assign dp_st.s_last      = (s_q == SW'(ALPHABET-1));
	assign dp_st.out_busy    = out_valid_q && !out_ready;

	assign out_valid     = out_valid_q;
	assign match_count   = out_match_q;
	assign total_matches = out_total_q;
	assign status        = out_status_q;

`ifndef NO_ASSERTIONS
	a_nodes_range: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_used_q != '0 && nodes_used_q <= (NW+1)'(NODES))
		else $error("node count out of range");
	a_walk_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, insert_q} < nodes_used_q && {1'b0, text_q} < nodes_used_q)
		else $error("insert or text node beyond allocated nodes");
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.op == acmc_pkg::OP_FINISH |-> !(out_valid_q && !out_ready))
		else $error("result loaded over a pending result");
`endif

endmodule

>>> rtl/aho_corasick_match_counter.sv
// A text symbol takes failure steps until a child matches, then sums matched suffix
//   nodes; an insert that allocates a new node clears its child row first.
// Build: scans every child slot of each queued node, plus failure walks.
//   One request in flight at a time; output register frees input.
// Reset clears control state, then a root row clearing pass runs
//   before the first request is accepted.
// ----------------------------------------------------------------------------
// aho_corasick_match_counter
// Multi-pattern matcher: trie insertion, breadth-first link build and text
// scanning with per-position and running saturating match counts.
// ----------------------------------------------------------------------------
module aho_corasick_match_counter #(
	parameter int NODES    = acmc_pkg::NODES_DEF,
	parameter int ALPHABET = acmc_pkg::ALPHABET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [acmc_pkg::CMD_W-1:0]    command,
	input  logic [acmc_pkg::SYM_W-1:0]    symbol,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [acmc_pkg::MATCH_W-1:0]  match_count,
	output logic [acmc_pkg::TOTAL_W-1:0]  total_matches,
	output logic [acmc_pkg::STATUS_W-1:0] status
);

	acmc_pkg::dp_cmd_t    dp_cmd;
	acmc_pkg::dp_status_t dp_st;

	acmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.dp_cmd   (dp_cmd),
		.dp_st    (dp_st)
	);

	acmc_datapath #(
		.NODES    (NODES),
		.ALPHABET (ALPHABET)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.command       (command),
		.symbol        (symbol),
		.dp_cmd        (dp_cmd),
		.dp_st         (dp_st),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.match_count   (match_count),
		.total_matches (total_matches),
		.status        (status)
	);

endmodule
